@@ design/charger_session_fsm_assert.svh @@
// Assertion macros shared by the charger session design.
// All properties are clocked on aclk and disabled while aresetn is low.
`ifndef CHARGER_SESSION_FSM_ASSERT_SVH
`define CHARGER_SESSION_FSM_ASSERT_SVH

// Same-cycle implication.
`define CSFSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CSFSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/csfsm_pkg.sv @@
`timescale 1ns / 1ps

package csfsm_pkg;

    localparam int NUM_EV = 11;

    // Pending-event bit positions
    localparam logic [3:0] EV_CONNECT      = 4'd0;
    localparam logic [3:0] EV_AUTH_REQUEST = 4'd1;
    localparam logic [3:0] EV_AUTH_ACCEPT  = 4'd2;
    localparam logic [3:0] EV_AUTH_REJECT  = 4'd3;
    localparam logic [3:0] EV_AUTH_INVALID = 4'd4;
    localparam logic [3:0] EV_AUTH_TIMEOUT = 4'd5;
    localparam logic [3:0] EV_START        = 4'd6;
    localparam logic [3:0] EV_COMPLETE     = 4'd7;
    localparam logic [3:0] EV_FAULT        = 4'd8;
    localparam logic [3:0] EV_RETRY        = 4'd9;
    localparam logic [3:0] EV_DISCONNECT   = 4'd10;

    // Authentication failure reasons
    localparam logic [1:0] RS_NONE     = 2'd0;
    localparam logic [1:0] RS_REJECTED = 2'd1;
    localparam logic [1:0] RS_INVALID  = 2'd2;
    localparam logic [1:0] RS_TIMEOUT  = 2'd3;

    typedef logic [NUM_EV-1:0] ev_vec_t;

    // Input beat: one pulse per event
    typedef struct packed {
        logic ev_connect;
        logic ev_auth_request;
        logic ev_auth_accept;
        logic ev_auth_reject;
        logic ev_auth_invalid;
        logic ev_auth_timeout;
        logic ev_start;
        logic ev_complete;
        logic ev_fault;
        logic ev_retry;
        logic ev_disconnect;
    } ev_beat_t;

    // Result beat
    typedef struct packed {
        logic [2:0]  session_state;
        logic [1:0]  fail_reason;
        ev_vec_t     pending_mask;
        logic        ready_entered;
        logic        ready_left;
        logic        charging_entered;
        logic        charging_left;
    } result_t;

    // Input register to step stage
    typedef struct packed {
        logic     valid;
        ev_beat_t beat;
    } stage_t;

    // Gather event pulses into pending-bit order
    function automatic ev_vec_t ev_to_vec(input ev_beat_t b);
        ev_vec_t v;
        v                  = '0;
        v[EV_CONNECT]      = b.ev_connect;
        v[EV_AUTH_REQUEST] = b.ev_auth_request;
        v[EV_AUTH_ACCEPT]  = b.ev_auth_accept;
        v[EV_AUTH_REJECT]  = b.ev_auth_reject;
        v[EV_AUTH_INVALID] = b.ev_auth_invalid;
        v[EV_AUTH_TIMEOUT] = b.ev_auth_timeout;
        v[EV_START]        = b.ev_start;
        v[EV_COMPLETE]     = b.ev_complete;
        v[EV_FAULT]        = b.ev_fault;
        v[EV_RETRY]        = b.ev_retry;
        v[EV_DISCONNECT]   = b.ev_disconnect;
        return v;
    endfunction

endpackage

@@ design/csfsm_in_reg.sv @@
`timescale 1ns / 1ps

module csfsm_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csfsm_pkg::ev_beat_t s_payload,
    input  logic                take,
    output csfsm_pkg::stage_t   stage
);

    logic                valid_reg;
    csfsm_pkg::ev_beat_t beat_reg;

    // Free when empty or when the step stage drains it this cycle
    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_payload;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.beat  = beat_reg;

endmodule

@@ design/csfsm_step.sv @@
`timescale 1ns / 1ps

module csfsm_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  csfsm_pkg::stage_t  stage,
    output logic               take,
    output logic               m_valid,
    input  logic               m_ready,
    output csfsm_pkg::result_t m_payload
);

`include "charger_session_fsm_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CONNECTED = 3'd1,
        ST_AUTH      = 3'd2,
        ST_FAILED    = 3'd3,
        ST_READY     = 3'd4,
        ST_CHARGING  = 3'd5,
        ST_FAULTED   = 3'd6
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          reason_reg, reason_next;
    csfsm_pkg::ev_vec_t  pending_reg, pending_next;
    csfsm_pkg::ev_vec_t  pend;
    logic                out_valid_reg;
    csfsm_pkg::result_t  result_reg, result_next;
    logic                step;
    logic                changed;

    // Result register is free when empty or being drained
    assign take = !out_valid_reg || m_ready;
    assign step = stage.valid && take;

    // Transition function: at most one move per beat, first match wins
    always_comb begin
        pend         = pending_reg | csfsm_pkg::ev_to_vec(stage.beat);
        state_next   = state_reg;
        reason_next  = reason_reg;
        pending_next = pend;
        unique case (state_reg)
            ST_IDLE: begin
                if (pend[csfsm_pkg::EV_CONNECT]) begin
                    state_next = ST_CONNECTED;
                    pending_next[csfsm_pkg::EV_CONNECT] = 1'b0;
                end
            end
            ST_CONNECTED: begin
                if (pend[csfsm_pkg::EV_AUTH_REQUEST]) begin
                    state_next = ST_AUTH;
                    pending_next[csfsm_pkg::EV_AUTH_REQUEST] = 1'b0;
                end
            end
            ST_AUTH: begin
                if (pend[csfsm_pkg::EV_AUTH_ACCEPT] && pend[csfsm_pkg::EV_AUTH_REJECT]) begin
                    // conflicting verdicts: fault, reason kept
                    state_next = ST_FAULTED;
                    pending_next[csfsm_pkg::EV_AUTH_ACCEPT] = 1'b0;
                    pending_next[csfsm_pkg::EV_AUTH_REJECT] = 1'b0;
                end else if (pend[csfsm_pkg::EV_AUTH_ACCEPT]) begin
                    state_next  = ST_READY;
                    reason_next = csfsm_pkg::RS_NONE;
                    pending_next[csfsm_pkg::EV_AUTH_ACCEPT] = 1'b0;
                end else if (pend[csfsm_pkg::EV_AUTH_REJECT]) begin
                    state_next  = ST_FAILED;
                    reason_next = csfsm_pkg::RS_REJECTED;
                    pending_next[csfsm_pkg::EV_AUTH_REJECT] = 1'b0;
                end else if (pend[csfsm_pkg::EV_AUTH_INVALID]) begin
                    state_next  = ST_FAILED;
                    reason_next = csfsm_pkg::RS_INVALID;
                    pending_next[csfsm_pkg::EV_AUTH_INVALID] = 1'b0;
                end else if (pend[csfsm_pkg::EV_AUTH_TIMEOUT]) begin
                    state_next  = ST_FAILED;
                    reason_next = csfsm_pkg::RS_TIMEOUT;
                    pending_next[csfsm_pkg::EV_AUTH_TIMEOUT] = 1'b0;
                end
            end
            ST_FAILED: begin
                if (pend[csfsm_pkg::EV_RETRY]) begin
                    state_next  = ST_AUTH;
                    reason_next = csfsm_pkg::RS_NONE;
                    pending_next[csfsm_pkg::EV_RETRY] = 1'b0;
                end else if (pend[csfsm_pkg::EV_DISCONNECT]) begin
                    state_next  = ST_IDLE;
                    reason_next = csfsm_pkg::RS_NONE;
                    pending_next[csfsm_pkg::EV_DISCONNECT] = 1'b0;
                end
            end
            ST_READY: begin
                if (pend[csfsm_pkg::EV_START]) begin
                    state_next = ST_CHARGING;
                    pending_next[csfsm_pkg::EV_START] = 1'b0;
                end
            end
            ST_CHARGING: begin
                if (pend[csfsm_pkg::EV_FAULT]) begin
                    state_next = ST_FAULTED;
                    pending_next[csfsm_pkg::EV_FAULT] = 1'b0;
                end else if (pend[csfsm_pkg::EV_COMPLETE]) begin
                    state_next = ST_READY;
                    pending_next[csfsm_pkg::EV_COMPLETE] = 1'b0;
                end
            end
            ST_FAULTED: begin
                // sticky until reset; events only accumulate
            end
            default: begin
                // unused code: no transition
            end
        endcase
    end

    // Result beat
    always_comb begin
        changed                      = (state_next != state_reg);
        result_next.session_state    = state_next;
        result_next.fail_reason      = reason_next;
        result_next.pending_mask     = pending_next;
        result_next.ready_entered    = changed && (state_next == ST_READY);
        result_next.ready_left       = changed && (state_reg == ST_READY);
        result_next.charging_entered = changed && (state_next == ST_CHARGING);
        result_next.charging_left    = changed && (state_reg == ST_CHARGING);
    end

    // Session state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            reason_reg    <= csfsm_pkg::RS_NONE;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                out_valid_reg <= stage.valid;
            end
            if (step) begin
                state_reg   <= state_next;
                reason_reg  <= reason_next;
                pending_reg <= pending_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = result_reg;

    // Checks
    `CSFSM_ASSERT_NEXT(a_fault_sticky, state_reg == ST_FAULTED, state_reg == ST_FAULTED,
        "faulted state was left without reset")
    `CSFSM_ASSERT_NOW(a_result_tracks_state, out_valid_reg,
        (result_reg.session_state == state_reg) && (result_reg.fail_reason == reason_reg)
        && (result_reg.pending_mask == pending_reg),
        "held result disagrees with session registers")
    `CSFSM_ASSERT_NOW(a_no_move_keeps_events, step && (state_next == state_reg),
        pending_next == pend, "event consumed without a transition")

endmodule

@@ design/charger_session_fsm.sv @@
`timescale 1ns / 1ps
// Charger session state machine: at most one transition per accepted beat.
// An accepted input beat passes the input register and then the result register before its result is valid.
// Throughput: one beat per cycle while m_ready is high; while the result register is stalled the
// input register takes a beat only when it is empty, and then holds that beat until the stall clears.
// Reset (aresetn low, synchronous): idle state, no reason, no pending events, pipe empty.

module charger_session_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csfsm_pkg::ev_beat_t s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output csfsm_pkg::result_t  m_payload
);

    csfsm_pkg::stage_t stage;
    logic              take;

    // Input register
    csfsm_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .take      (take),
        .stage     (stage)
    );

    // Transition step and result register
    csfsm_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage     (stage),
        .take      (take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
